// ===== design/led_strip_pattern_generator_macros.svh =====
// Assertion macros for the LED strip pattern generator.
`ifndef LED_STRIP_PATTERN_GENERATOR_MACROS_SVH
`define LED_STRIP_PATTERN_GENERATOR_MACROS_SVH

// same-cycle implication
`define LSPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lspg_pkg.sv =====
// Shared types, constants and color tables for the LED strip pattern generator.
package lspg_pkg;

  localparam int unsigned LedCount = 16;
  localparam int unsigned PixW     = 6;
  localparam int unsigned StageW   = 7;
  localparam int unsigned TimeW    = 11;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned PatW     = 5;
  localparam int unsigned LevelW   = 8;

  localparam logic [TimeW-1:0] TimeMax     = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] PeriodSolid = 11'd1000;
  localparam logic [TimeW-1:0] PeriodFlash = 11'd250;
  localparam logic [TimeW-1:0] PeriodChase = 11'd100;

  // pattern code boundaries
  localparam logic [PatW-1:0] PatSolidMax  = 5'd5;
  localparam logic [PatW-1:0] PatFlashBase = 5'd5;
  localparam logic [PatW-1:0] PatFlashMax  = 5'd10;
  localparam logic [PatW-1:0] PatAltBase   = 5'd11;
  localparam logic [PatW-1:0] PatAltMax    = 5'd17;
  localparam logic [PatW-1:0] PatChaseBase = 5'd17;
  localparam logic [PatW-1:0] PatChaseMax  = 5'd22;

  localparam logic [StageW-1:0] StageLast = StageW'(LedCount);
  localparam logic [PixW-1:0]   PixLast   = PixW'(LedCount - 1);

  typedef enum logic [2:0] {
    ColOff    = 3'd0,
    ColRed    = 3'd1,
    ColGreen  = 3'd2,
    ColBlue   = 3'd3,
    ColYellow = 3'd4,
    ColPurple = 3'd5
  } colour_e;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } rgb_t;

  // one frame to render
  typedef struct packed {
    rgb_t              rgb;
    logic              chase;
    logic [StageW-1:0] stage;
  } frame_t;

  function automatic rgb_t colour_rgb(logic [2:0] c);
    rgb_t r;
    r = '0;
    case (c)
      ColRed:    r = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      ColGreen:  r = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
      ColBlue:   r = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
      ColYellow: r = '{red: 8'hFF, green: 8'hFF, blue: 8'h00};
      ColPurple: r = '{red: 8'h00, green: 8'hFF, blue: 8'hFF};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic colour_e alt_first(logic [2:0] k);
    colour_e c;
    c = ColOff;
    case (k)
      3'd0, 3'd1, 3'd2, 3'd3: c = ColRed;
      3'd4, 3'd5, 3'd6:       c = ColGreen;
      default:                c = ColOff;
    endcase
    return c;
  endfunction

  function automatic colour_e alt_second(logic [2:0] k);
    colour_e c;
    c = ColOff;
    case (k)
      3'd0:       c = ColGreen;
      3'd1, 3'd4: c = ColBlue;
      3'd2, 3'd5: c = ColYellow;
      3'd3, 3'd6: c = ColPurple;
      default:    c = ColOff;
    endcase
    return c;
  endfunction

endpackage

// ===== design/lspg_timer.sv =====
// Tick input register, frame timer, pattern state and frame descriptor issue.
module lspg_timer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lspg_pkg::PatW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lspg_pkg::ElapsedW-1:0] elapsed_ms_i,
  output logic                         frame_vld_o,
  input  logic                         frame_rdy_i,
  output lspg_pkg::frame_t             frame_o
);

  logic                            in_vld_q;
  logic [lspg_pkg::ElapsedW-1:0]   elapsed_q;
  logic [lspg_pkg::PatW-1:0]       pat_q, pat_d;
  logic [lspg_pkg::TimeW-1:0]      time_q, time_d;
  logic [lspg_pkg::StageW-1:0]     stage_q, stage_d;

  logic [lspg_pkg::TimeW:0]        sum;
  logic [lspg_pkg::TimeW-1:0]      t_sat;
  logic [lspg_pkg::TimeW-1:0]      period;
  logic                            invalid;
  logic                            fire;
  logic                            consume;
  logic [lspg_pkg::StageW-1:0]     s_clamp;
  logic [lspg_pkg::StageW-1:0]     s_next;
  logic                            in_take;

  assign sum     = {1'b0, time_q} + (lspg_pkg::TimeW + 1)'(elapsed_q);
  assign t_sat   = sum[lspg_pkg::TimeW] ? lspg_pkg::TimeMax : sum[lspg_pkg::TimeW-1:0];
  assign invalid = pat_q > lspg_pkg::PatChaseMax;

  always_comb begin
    if (pat_q <= lspg_pkg::PatSolidMax) begin
      period = lspg_pkg::PeriodSolid;
    end else if (pat_q <= lspg_pkg::PatAltMax) begin
      period = lspg_pkg::PeriodFlash;
    end else begin
      period = lspg_pkg::PeriodChase;
    end
  end

  assign fire        = in_vld_q && !invalid && (t_sat > period);
  assign frame_vld_o = fire;
  assign consume     = in_vld_q && (!fire || frame_rdy_i);
  assign in_stall_o  = in_vld_q && !consume;
  assign in_take     = in_valid_i && !in_stall_o;

  assign s_clamp = (stage_q > lspg_pkg::StageLast) ? '0 : stage_q;
  assign s_next  = (s_clamp == lspg_pkg::StageLast) ? '0 : s_clamp + 7'd1;

  // frame descriptor for the current pattern and stage
  always_comb begin
    frame_o = '0;
    if (pat_q <= lspg_pkg::PatSolidMax) begin
      frame_o.rgb = lspg_pkg::colour_rgb(pat_q[2:0]);
    end else if (pat_q <= lspg_pkg::PatFlashMax) begin
      frame_o.rgb = (stage_q != '0)
                  ? lspg_pkg::colour_rgb(3'(pat_q - lspg_pkg::PatFlashBase)) : '0;
    end else if (pat_q <= lspg_pkg::PatAltMax) begin
      frame_o.rgb = (stage_q == '0)
                  ? lspg_pkg::colour_rgb(lspg_pkg::alt_first(3'(pat_q - lspg_pkg::PatAltBase)))
                  : lspg_pkg::colour_rgb(lspg_pkg::alt_second(3'(pat_q - lspg_pkg::PatAltBase)));
    end else begin
      frame_o.rgb   = lspg_pkg::colour_rgb(3'(pat_q - lspg_pkg::PatChaseBase));
      frame_o.chase = 1'b1;
      frame_o.stage = s_clamp;
    end
  end

  always_comb begin
    pat_d   = pat_q;
    time_d  = time_q;
    stage_d = stage_q;
    if (cfg_we_i && (cfg_wdata_i != pat_q)) begin
      pat_d   = cfg_wdata_i;
      time_d  = lspg_pkg::TimeMax;
      stage_d = '0;
    end else if (consume) begin
      if (invalid || fire) begin
        time_d = '0;
      end else begin
        time_d = t_sat;
      end
      if (fire) begin
        if (pat_q > lspg_pkg::PatAltMax) begin
          stage_d = s_next;
        end else if (pat_q > lspg_pkg::PatSolidMax) begin
          stage_d = (stage_q == '0) ? 7'd1 : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      pat_q    <= '0;
      time_q   <= lspg_pkg::TimeMax;
      stage_q  <= '0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !consume);
      pat_q    <= pat_d;
      time_q   <= time_d;
      stage_q  <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      elapsed_q <= elapsed_ms_i;
    end
  end

endmodule

// ===== design/lspg_render.sv =====
// Frame register and pixel sequencer feeding the result register.
module lspg_render (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          frame_vld_i,
  output logic                          frame_rdy_o,
  input  lspg_pkg::frame_t              frame_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lspg_pkg::PixW-1:0]     pixel_index_o,
  output logic [lspg_pkg::LevelW-1:0]   red_level_o,
  output logic [lspg_pkg::LevelW-1:0]   green_level_o,
  output logic [lspg_pkg::LevelW-1:0]   blue_level_o,
  output logic                          frame_end_o
);

  logic                        desc_vld_q;
  lspg_pkg::frame_t            desc_q;
  logic [lspg_pkg::PixW-1:0]   pix_q;
  logic                        out_vld_q;
  logic [lspg_pkg::PixW-1:0]   idx_q;
  lspg_pkg::rgb_t              rgb_q;
  logic                        end_q;

  logic                        out_free;
  logic                        emit;
  logic                        last;
  logic                        lit;
  logic [lspg_pkg::StageW-1:0] pix_ext;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign emit        = desc_vld_q && out_free;
  assign last        = pix_q == lspg_pkg::PixLast;
  assign frame_rdy_o = !desc_vld_q || (out_free && last);
  assign pix_ext     = {1'b0, pix_q};

  always_comb begin
    if (!desc_q.chase) begin
      lit = 1'b1;
    end else if (desc_q.stage == lspg_pkg::StageLast) begin
      lit = pix_q == '0;
    end else begin
      lit = (pix_ext == desc_q.stage) || (pix_ext == desc_q.stage + 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_vld_q <= 1'b0;
      pix_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (frame_vld_i && frame_rdy_o) begin
        desc_vld_q <= 1'b1;
      end else if (emit && last) begin
        desc_vld_q <= 1'b0;
      end
      if (emit) begin
        pix_q <= last ? '0 : pix_q + 6'd1;
      end
      if (out_free) begin
        out_vld_q <= desc_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_vld_i && frame_rdy_o) begin
      desc_q <= frame_i;
    end
    if (emit) begin
      idx_q <= pix_q;
      rgb_q <= lit ? desc_q.rgb : '0;
      end_q <= last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_index_o = idx_q;
  assign red_level_o   = rgb_q.red;
  assign green_level_o = rgb_q.green;
  assign blue_level_o  = rgb_q.blue;
  assign frame_end_o   = end_q;

endmodule

// ===== design/led_strip_pattern_generator.sv =====
// Top level of the LED strip pattern generator.
//
//   port group   | dir | handshake                | word
//   tick         | in  | in_valid_i / in_stall_o  | elapsed_ms_i
//   pixel        | out | out_valid_o / out_stall_i| index, red, green, blue, frame_end
//   pattern cfg  | in  | cfg_we_i                 | cfg_wdata_i
//
// One tick word can enter every cycle unless a tick that starts a frame is waiting.
// A frame streams 16 pixels (one per pixel of the strip) at one per cycle from the
// pixel sequencer while the output is not stalled; that counter sets the frame length.
// A tick reaches its first pixel through the input, frame and result registers.
// A tick that starts a frame waits in the input register while a previous frame
// still holds the frame register. Reset leaves the timer saturated, so the first
// tick emits a frame. Output stall holds the result register and backs up the chain.
module led_strip_pattern_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lspg_pkg::PatW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lspg_pkg::ElapsedW-1:0] elapsed_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lspg_pkg::PixW-1:0]     pixel_index_o,
  output logic [lspg_pkg::LevelW-1:0]   red_level_o,
  output logic [lspg_pkg::LevelW-1:0]   green_level_o,
  output logic [lspg_pkg::LevelW-1:0]   blue_level_o,
  output logic                          frame_end_o
);

  `include "led_strip_pattern_generator_macros.svh"

  logic             frame_vld;
  logic             frame_rdy;
  lspg_pkg::frame_t frame;

  lspg_timer u_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elapsed_ms_i (elapsed_ms_i),
    .frame_vld_o  (frame_vld),
    .frame_rdy_i  (frame_rdy),
    .frame_o      (frame)
  );

  lspg_render u_render (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_vld_i   (frame_vld),
    .frame_rdy_o   (frame_rdy),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .frame_end_o   (frame_end_o)
  );

  `LSPG_ASSERT_NOW(a_end_on_last, clk_i, rst_ni,
                   out_valid_o && frame_end_o,
                   pixel_index_o == lspg_pkg::PixLast,
                   "frame_end off the last pixel")
  `LSPG_ASSERT_NEXT(a_frame_no_gap, clk_i, rst_ni,
                    out_valid_o && !out_stall_i && !frame_end_o,
                    out_valid_o && (pixel_index_o == $past(pixel_index_o) + 6'd1),
                    "frame broken or pixel skipped")
  `LSPG_ASSERT_NOW(a_stall_cause, clk_i, rst_ni,
                   in_stall_o,
                   frame_vld && !frame_rdy,
                   "input stalled without a blocked frame")

endmodule

// ===== dv/led_strip_pattern_generator_tb.sv =====
// Self-checking testbench for the LED strip pattern generator.
module led_strip_pattern_generator_tb;
  import lspg_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 10;
  localparam int ElapsedMax   = (1 << ElapsedW) - 1;

  typedef enum logic [PatW-1:0] {
    SolidOff, SolidRed, SolidGreen, SolidBlue, SolidYellow, SolidPurple,
    FlashRed, FlashGreen, FlashBlue, FlashYellow, FlashPurple,
    AltRedGreen, AltRedBlue, AltRedYellow, AltRedPurple,
    AltGreenBlue, AltGreenYellow, AltGreenPurple,
    ChaseRed, ChaseGreen, ChaseBlue, ChaseYellow, ChasePurple,
    PatInvalidFirst, PatInvalidLast = 5'd31
  } pattern_e;

  typedef struct packed {
    logic [PixW-1:0] index;
    rgb_t            rgb;
    logic            frame_end;
  } pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PatW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ElapsedW-1:0] elapsed_ms_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     pixel_index_o;
  logic [LevelW-1:0]   red_level_o;
  logic [LevelW-1:0]   green_level_o;
  logic [LevelW-1:0]   blue_level_o;
  logic                frame_end_o;

  // predictor state
  logic [PatW-1:0]   pattern_sel;
  logic [TimeW-1:0]  ms_since_frame;
  logic [StageW-1:0] stage;
  pixel_t            expected_pixels[$];

  int     idle_pct;
  int     stall_pct;
  int     errors;
  int     cycles;
  pixel_t want;

  led_strip_pattern_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .elapsed_ms_i  (elapsed_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic rgb_t level_of(input colour_e c);
    rgb_t lv;
    lv = '0;
    case (c)
      ColRed:    lv.red = 8'hFF;
      ColGreen:  lv.green = 8'hFF;
      ColBlue:   lv.blue = 8'hFF;
      ColYellow: begin
        lv.red   = 8'hFF;
        lv.green = 8'hFF;
      end
      ColPurple: begin
        lv.green = 8'hFF;
        lv.blue  = 8'hFF;
      end
      default:   lv = '0;
    endcase
    return lv;
  endfunction

  function automatic colour_e alternation_colour(input logic [PatW-1:0] p, input logic second);
    colour_e c;
    case (p)
      AltRedGreen:    c = second ? ColGreen  : ColRed;
      AltRedBlue:     c = second ? ColBlue   : ColRed;
      AltRedYellow:   c = second ? ColYellow : ColRed;
      AltRedPurple:   c = second ? ColPurple : ColRed;
      AltGreenBlue:   c = second ? ColBlue   : ColGreen;
      AltGreenYellow: c = second ? ColYellow : ColGreen;
      default:        c = second ? ColPurple : ColGreen;
    endcase
    return c;
  endfunction

  // adds the tick to the frame timer and queues the frame it triggers, if any
  task automatic predict_tick(input logic [ElapsedW-1:0] ms);
    logic [TimeW:0]    sum;
    logic [TimeW-1:0]  period;
    logic [StageW-1:0] s;
    colour_e           c;
    logic              lit;
    pixel_t            pix;
    sum = {1'b0, ms_since_frame} + (TimeW + 1)'(ms);
    if (sum > TimeMax) sum = (TimeW + 1)'(TimeMax);
    ms_since_frame = sum[TimeW-1:0];
    if (pattern_sel > ChasePurple) begin
      ms_since_frame = '0;
      return;
    end
    if (pattern_sel <= SolidPurple) period = PeriodSolid;
    else if (pattern_sel <= AltGreenPurple) period = PeriodFlash;
    else period = PeriodChase;
    if (ms_since_frame <= period) return;
    ms_since_frame = '0;
    s = (stage > StageLast) ? '0 : stage;
    for (int i = 0; i < LedCount; i++) begin
      if (pattern_sel <= SolidPurple) begin
        c = colour_e'(pattern_sel[2:0]);
      end else if (pattern_sel <= FlashPurple) begin
        c = (stage != '0) ? colour_e'(3'(pattern_sel - SolidPurple)) : ColOff;
      end else if (pattern_sel <= AltGreenPurple) begin
        c = alternation_colour(pattern_sel, stage != '0);
      end else begin
        if (s == StageLast) lit = (i == 0);
        else lit = (i == int'(s)) || (i == int'(s) + 1);
        c = lit ? colour_e'(3'(pattern_sel - AltGreenPurple)) : ColOff;
      end
      pix.index     = PixW'(i);
      pix.rgb       = level_of(c);
      pix.frame_end = (i == LedCount - 1);
      expected_pixels.push_back(pix);
    end
    if (pattern_sel <= SolidPurple) begin
      stage = stage;
    end else if (pattern_sel <= AltGreenPurple) begin
      stage = (stage == '0) ? StageW'(1) : '0;
    end else begin
      stage = (s == StageLast) ? '0 : s + StageW'(1);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel word, index %0d", pixel_index_o));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_index_o !== want.index)
          report_mismatch($sformatf("index got %0d want %0d", pixel_index_o, want.index));
        if (red_level_o !== want.rgb.red)
          report_mismatch($sformatf("red at %0d got %0h want %0h",
                                    want.index, red_level_o, want.rgb.red));
        if (green_level_o !== want.rgb.green)
          report_mismatch($sformatf("green at %0d got %0h want %0h",
                                    want.index, green_level_o, want.rgb.green));
        if (blue_level_o !== want.rgb.blue)
          report_mismatch($sformatf("blue at %0d got %0h want %0h",
                                    want.index, blue_level_o, want.rgb.blue));
        if (frame_end_o !== want.frame_end)
          report_mismatch($sformatf("frame_end at %0d got %0b want %0b",
                                    want.index, frame_end_o, want.frame_end));
      end
    end
  end

  task automatic send_tick(input logic [ElapsedW-1:0] ms);
    logic stalled;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elapsed_ms_i <= ms;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    predict_tick(ms);
  endtask

  // wait until every queued pixel is out and the pipeline has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_pattern(input logic [PatW-1:0] code);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (code != pattern_sel) begin
      pattern_sel    = code;
      stage          = '0;
      ms_since_frame = TimeMax;
    end
  endtask

  function automatic logic [ElapsedW-1:0] pick_elapsed(input logic [PatW-1:0] code);
    int per;
    int hi;
    if (code <= SolidPurple) per = int'(PeriodSolid);
    else if (code <= AltGreenPurple) per = int'(PeriodFlash);
    else per = int'(PeriodChase);
    hi = (per + 20 > ElapsedMax) ? ElapsedMax : per + 20;
    if (code >= ChaseRed && code <= ChasePurple && $urandom_range(3) != 0)
      return ElapsedW'($urandom_range(hi, per + 1));
    case ($urandom_range(3))
      0:       return ElapsedW'($urandom_range(ElapsedMax, 0));
      1:       return ElapsedW'($urandom_range(per / 2 + 5, per / 2 - 5));
      2:       return ElapsedW'($urandom_range(hi, per - 3));
      default: return ElapsedW'($urandom_range(15, 0));
    endcase
  endfunction

  // saturated timer after reset, exact period boundary, one past it
  task automatic test_timer_edges();
    idle_pct  = 0;
    stall_pct = 0;
    send_tick(ElapsedW'(ElapsedMax));
    send_tick(ElapsedW'(PeriodSolid));
    send_tick('0);
    send_tick(ElapsedW'(1));
  endtask

  // each write of a new valid code forces a frame on the next tick; invalid codes give none
  task automatic test_every_pattern();
    for (int p = SolidOff; p <= ChasePurple; p++) begin
      write_pattern(PatW'(p));
      send_tick('0);
    end
    write_pattern(PatInvalidFirst);
    send_tick(ElapsedW'(ElapsedMax));
    write_pattern(PatInvalidLast);
    send_tick(ElapsedW'(ElapsedMax));
  endtask

  // rewriting the current code must not force a frame
  task automatic test_same_write();
    write_pattern(SolidRed);
    send_tick('0);
    write_pattern(SolidRed);
    send_tick('0);
  endtask

  task automatic test_random(input int idle, input int stall, input int n_items);
    int              sent;
    int              len;
    logic [PatW-1:0] code;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) code = PatW'($urandom_range(PatInvalidLast, PatInvalidFirst));
      else if ($urandom_range(7) == 0) code = pattern_sel;
      else code = PatW'($urandom_range(ChasePurple, SolidOff));
      write_pattern(code);
      if (code >= ChaseRed && code <= ChasePurple) len = $urandom_range(24, 6);
      else len = $urandom_range(8, 1);
      repeat (len) begin
        if ($urandom_range(15) == 0) drain();
        send_tick(pick_elapsed(code));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    elapsed_ms_i   = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    errors         = 0;
    cycles         = 0;
    pattern_sel    = SolidOff;
    ms_since_frame = TimeMax;
    stage          = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_timer_edges();
    test_every_pattern();
    test_same_write();
    test_random(0, 0, 35);
    test_random(71, 0, 35);
    test_random(0, 71, 35);
    test_random(21, 21, 35);
    drain();
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixel words never arrived", expected_pixels.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lspg_pkg.sv
design/lspg_timer.sv
design/lspg_render.sv
design/led_strip_pattern_generator.sv
dv/led_strip_pattern_generator_tb.sv
